// ===== src/efp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and a helper function of the escape-time fractal pixel unit.
package efp_pkg;

   localparam int CFG_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int IDX_W     = 13;
   localparam int ITER_W    = 10;
   localparam int HUE_W     = 8;

   localparam int MANDEL_RADIUS = 20;
   localparam int JULIA_RADIUS  = 2;
   localparam int HUE_MOD       = 255;

   localparam logic [CFG_W-1:0]  ORIGIN_RESET   = 32'hE000_0000;
   localparam logic [CFG_W-1:0]  STEP_RESET     = 32'd536871;
   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 10'd400;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRACTAL_MODE = 3'd0,
      REG_JULIA_C_RE   = 3'd1,
      REG_JULIA_C_IM   = 3'd2,
      REG_X_ORIGIN     = 3'd3,
      REG_Y_ORIGIN     = 3'd4,
      REG_STEP_X       = 3'd5,
      REG_STEP_Y       = 3'd6,
      REG_MAX_ITER     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                    fractal_mode;
      logic signed [CFG_W-1:0] julia_c_re;
      logic signed [CFG_W-1:0] julia_c_im;
      logic signed [CFG_W-1:0] x_origin;
      logic signed [CFG_W-1:0] y_origin;
      logic signed [CFG_W-1:0] step_x;
      logic signed [CFG_W-1:0] step_y;
      logic [ITER_W-1:0]       max_iter;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] column;
      logic [IDX_W-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]  pixel_column;
      logic [IDX_W-1:0]  pixel_row;
      logic [ITER_W-1:0] iter_count;
      logic              escaped;
      logic [HUE_W-1:0]  hue;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic point_mul;
      logic point_init;
      logic mul_lo;
      logic mul_hi;
      logic mul_sum;
      logic iter_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic at_limit;
      logic bailout;
   } sts_type;

   // Hue is the count (tripled in Mandelbrot mode) modulo 255, folded as 256 = 1 mod 255.
   function automatic logic [HUE_W-1:0] hue_of(input logic [ITER_W-1:0] count,
                                              input logic mandel);
      logic [ITER_W+1:0] scaled;
      logic [8:0]        folded;
      scaled = mandel ? ((ITER_W+2)'(count) + ((ITER_W+2)'(count) << 1))
                      : (ITER_W+2)'(count);
      folded = 9'(scaled[ITER_W+1:8]) + 9'(scaled[7:0]);
      if (folded >= 9'(HUE_MOD)) begin
         folded = folded - 9'(HUE_MOD);
      end
      return folded[HUE_W-1:0];
   endfunction

endpackage

// ===== src/efp_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream interface that carries one payload per transaction.
interface efp_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/efp_csr.sv =====
`timescale 1ns / 1ps
// Configuration register file of the escape-time fractal pixel unit.
module efp_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [efp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [efp_pkg::CFG_W-1:0]             csr_wr_data,
   output efp_pkg::cfg_type                      cfg
);

   efp_pkg::cfg_type cfg_ff;
   efp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (efp_pkg::csr_index_type'(csr_index))
            efp_pkg::REG_FRACTAL_MODE: cfg_in.fractal_mode = csr_wr_data[0];
            efp_pkg::REG_JULIA_C_RE:   cfg_in.julia_c_re   = csr_wr_data;
            efp_pkg::REG_JULIA_C_IM:   cfg_in.julia_c_im   = csr_wr_data;
            efp_pkg::REG_X_ORIGIN:     cfg_in.x_origin     = csr_wr_data;
            efp_pkg::REG_Y_ORIGIN:     cfg_in.y_origin     = csr_wr_data;
            efp_pkg::REG_STEP_X:       cfg_in.step_x       = csr_wr_data;
            efp_pkg::REG_STEP_Y:       cfg_in.step_y       = csr_wr_data;
            efp_pkg::REG_MAX_ITER:     cfg_in.max_iter     = csr_wr_data[efp_pkg::ITER_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fractal_mode <= 1'b0;
         cfg_ff.julia_c_re   <= '0;
         cfg_ff.julia_c_im   <= '0;
         cfg_ff.x_origin     <= efp_pkg::ORIGIN_RESET;
         cfg_ff.y_origin     <= efp_pkg::ORIGIN_RESET;
         cfg_ff.step_x       <= efp_pkg::STEP_RESET;
         cfg_ff.step_y       <= efp_pkg::STEP_RESET;
         cfg_ff.max_iter     <= efp_pkg::MAX_ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/efp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the escape-time fractal pixel unit.
module efp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  efp_pkg::sts_type  sts,
   output efp_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_INIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_TEST,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.point_mul = 1'b1;
            state_in      = ST_INIT;
         end
         ST_INIT: begin
            cmd.point_init = 1'b1;
            state_in       = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            if (sts.at_limit) begin
               state_in = ST_DONE;
            end else begin
               cmd.mul_lo = 1'b1;
               state_in   = ST_MUL_HI;
            end
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.mul_sum = 1'b1;
            state_in    = ST_TEST;
         end
         ST_TEST: begin
            cmd.iter_step = 1'b1;
            state_in      = sts.bailout ? ST_DONE : ST_MUL_LO;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/efp_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the escape-time fractal pixel unit: grid point, iteration and result register.
module efp_dpath #(
   parameter int GRID_MAX        = 8192,
   parameter int COORD_FRAC_BITS = 28
) (
   input  logic                      clock,
   input  efp_pkg::cfg_type          cfg,
   input  efp_pkg::req_payload_type  req_payload,
   input  efp_pkg::cmd_type          cmd,
   output efp_pkg::sts_type          sts,
   output efp_pkg::rsp_payload_type  rsp_payload
);

   localparam int F   = COORD_FRAC_BITS;
   localparam int ZW  = (((F + 10) > 32) ? (F + 10) : 32) + 1;
   localparam int MW  = ZW - 1;
   localparam int HL  = (MW + 1) / 2;
   localparam int PW  = 2 * MW;
   localparam int SW  = PW - F;
   localparam int PPW = efp_pkg::IDX_W + 1 + efp_pkg::CFG_W;
   localparam int PSW = PPW + 1;
   localparam int CW  = efp_pkg::CFG_W;
   localparam logic [SW:0] LIMIT_MANDEL =
      (SW + 1)'(efp_pkg::MANDEL_RADIUS * efp_pkg::MANDEL_RADIUS) << F;
   localparam logic [SW:0] LIMIT_JULIA =
      (SW + 1)'(efp_pkg::JULIA_RADIUS * efp_pkg::JULIA_RADIUS) << F;

   logic [efp_pkg::IDX_W-1:0]  col_ff;
   logic [efp_pkg::IDX_W-1:0]  row_ff;
   logic signed [PPW-1:0]      prod_x_ff;
   logic signed [PPW-1:0]      prod_y_ff;
   logic signed [ZW-1:0]       zre_ff;
   logic signed [ZW-1:0]       zim_ff;
   logic signed [CW-1:0]       cre_ff;
   logic signed [CW-1:0]       cim_ff;
   logic [efp_pkg::ITER_W-1:0] k_ff;
   logic                       esc_ff;
   logic [MW+HL-1:0]           p_lo_ff [3];
   logic [MW+HL-1:0]           p_hi_ff [3];
   logic [SW-1:0]              sq_ff [3];
   efp_pkg::rsp_payload_type   out_ff;

   logic [efp_pkg::IDX_W-1:0]  cidx_x;
   logic [efp_pkg::IDX_W-1:0]  cidx_y;
   logic signed [PSW-1:0]      sum_x;
   logic signed [PSW-1:0]      sum_y;
   logic signed [CW-1:0]       pre;
   logic signed [CW-1:0]       pim;
   logic [MW-1:0]              mag_re;
   logic [MW-1:0]              mag_im;
   logic [MW-1:0]              opa [3];
   logic [MW-1:0]              opb [3];
   logic [HL-1:0]              bsel [3];
   logic [MW+HL-1:0]           mul [3];
   logic [PW-1:0]              full [3];
   logic [SW:0]                mag_sum;
   logic [SW:0]                limit;
   logic                       over;
   logic signed [ZW-1:0]       zre_n;
   logic signed [ZW-1:0]       zim_n;
   logic [ZW-1:0]              ri_t;
   logic [ZW-1:0]              twice;

   always_comb begin
      cidx_x = (32'(col_ff) >= GRID_MAX) ? efp_pkg::IDX_W'(GRID_MAX - 1) : col_ff;
      cidx_y = (32'(row_ff) >= GRID_MAX) ? efp_pkg::IDX_W'(GRID_MAX - 1) : row_ff;

      sum_x = PSW'(prod_x_ff) + PSW'(cfg.x_origin);
      sum_y = PSW'(prod_y_ff) + PSW'(cfg.y_origin);
      if (sum_x[PSW-1:CW-1] == '0 || sum_x[PSW-1:CW-1] == '1) begin
         pre = sum_x[CW-1:0];
      end else begin
         pre = sum_x[PSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
      if (sum_y[PSW-1:CW-1] == '0 || sum_y[PSW-1:CW-1] == '1) begin
         pim = sum_y[CW-1:0];
      end else begin
         pim = sum_y[PSW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end

      mag_re = zre_ff[ZW-1] ? MW'(-zre_ff) : MW'(zre_ff);
      mag_im = zim_ff[ZW-1] ? MW'(-zim_ff) : MW'(zim_ff);
      opa[0] = mag_re;
      opb[0] = mag_re;
      opa[1] = mag_im;
      opb[1] = mag_im;
      opa[2] = mag_re;
      opb[2] = mag_im;
      for (int u = 0; u < 3; u++) begin
         bsel[u] = cmd.mul_hi ? HL'(opb[u][MW-1:HL]) : opb[u][HL-1:0];
         mul[u]  = (MW + HL)'(opa[u]) * (MW + HL)'(bsel[u]);
         full[u] = PW'(p_lo_ff[u]) + (PW'(p_hi_ff[u]) << HL);
      end

      mag_sum = (SW + 1)'(sq_ff[0]) + (SW + 1)'(sq_ff[1]);
      limit   = cfg.fractal_mode ? LIMIT_MANDEL : LIMIT_JULIA;
      over    = (mag_sum >= limit);

      zre_n = ZW'(sq_ff[0]) - ZW'(sq_ff[1]) + ZW'(cre_ff);
      ri_t  = ZW'(sq_ff[2]);
      twice = ri_t << 1;
      zim_n = ((zre_ff[ZW-1] ^ zim_ff[ZW-1]) ? (ZW'(0) - twice) : twice) + ZW'(cim_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_payload.column;
         row_ff <= req_payload.row;
      end
      if (cmd.point_mul) begin
         prod_x_ff <= PPW'($signed({1'b0, cidx_x})) * PPW'(cfg.step_x);
         prod_y_ff <= PPW'($signed({1'b0, cidx_y})) * PPW'(cfg.step_y);
      end
      if (cmd.point_init) begin
         k_ff   <= '0;
         esc_ff <= 1'b0;
         if (cfg.fractal_mode) begin
            zre_ff <= '0;
            zim_ff <= '0;
            cre_ff <= pre;
            cim_ff <= pim;
         end else begin
            zre_ff <= ZW'(pre);
            zim_ff <= ZW'(pim);
            cre_ff <= cfg.julia_c_re;
            cim_ff <= cfg.julia_c_im;
         end
      end
      for (int u = 0; u < 3; u++) begin
         if (cmd.mul_lo) begin
            p_lo_ff[u] <= mul[u];
         end
         if (cmd.mul_hi) begin
            p_hi_ff[u] <= mul[u];
         end
         if (cmd.mul_sum) begin
            sq_ff[u] <= full[u][PW-1:F];
         end
      end
      if (cmd.iter_step) begin
         if (over) begin
            esc_ff <= 1'b1;
         end else begin
            zre_ff <= zre_n;
            zim_ff <= zim_n;
            k_ff   <= k_ff + efp_pkg::ITER_W'(1);
         end
      end
      if (cmd.out_load) begin
         out_ff.pixel_column <= col_ff;
         out_ff.pixel_row    <= row_ff;
         out_ff.iter_count   <= k_ff;
         out_ff.escaped      <= esc_ff;
         out_ff.hue          <= efp_pkg::hue_of(k_ff, cfg.fractal_mode);
      end
   end

   assign sts.at_limit = (k_ff == cfg.max_iter);
   assign sts.bailout  = over;
   assign rsp_payload  = out_ff;

endmodule

// ===== src/escape_time_fractal_pixel_unit.sv =====
`timescale 1ns / 1ps
// Top level of the escape-time fractal pixel unit (Mandelbrot and Julia sets).
//
// The req_if channel takes one pixel (column, row) per transaction; the rsp_if
// channel returns one result per pixel with the echoed indices, the iteration
// count, the escaped flag and the hue, in the order the pixels were taken.
// Registers are written through csr_wr_en, csr_index and csr_wr_data; the user
// must do so only while the unit is idle, which the block itself does not
// enforce. One pixel is worked on at a time: each iteration of z <- z*z + c
// passes through ST_MUL_LO, ST_MUL_HI, ST_SUM and ST_TEST, since the two
// squares and the cross product are each formed from two half-width partial
// products and then summed before the bailout test. The unit is ready for the
// next pixel in the cycle after the result is loaded. The result sits in
// an output register, so the next pixel is taken while it waits; if the
// receiver has not taken it by the time the following result is ready, the
// unit holds that result until the register frees up. A synchronous reset
// clears the sequencer and the result valid flag and loads the default view.
module escape_time_fractal_pixel_unit #(
   parameter int GRID_MAX        = 8192,
   parameter int COORD_FRAC_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   efp_stream_if.sink                    req_if,
   efp_stream_if.source                  rsp_if,
   input  logic                          csr_wr_en,
   input  logic [efp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [efp_pkg::CFG_W-1:0]     csr_wr_data
);

   efp_pkg::cfg_type         cfg;
   efp_pkg::cmd_type         cmd;
   efp_pkg::sts_type         sts;
   efp_pkg::req_payload_type req_payload;
   efp_pkg::rsp_payload_type rsp_payload;

   assign req_payload    = req_if.payload;
   assign rsp_if.payload = rsp_payload;

   efp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   efp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   efp_dpath #(
      .GRID_MAX        (GRID_MAX),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .cfg         (cfg),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule
